### rtl/heading_bias_calibrator_assert.svh
// Assertion macros for the heading bias calibrator checker.
// Needs clk and rst_n visible where the macros are used.
`ifndef HEADING_BIAS_CALIBRATOR_ASSERT_SVH
`define HEADING_BIAS_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define HBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define HBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/hbc_pkg.sv
// Shared types, widths and the arctangent table of the heading bias calibrator.
// No dependencies.
package hbc_pkg;

    localparam int POS_W  = 32;
    localparam int DIFF_W = 33;
    localparam int ANG_W  = 16;
    localparam int SUM_W  = 48;
    localparam int CNT_W  = 32;
    localparam int VEC_W  = 36;
    localparam int Z_W    = 32;
    localparam int SD_W   = 16;
    localparam int SQ_W   = 17;
    localparam int ATAN_IDX_W = 5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ_E,
        ST_SQ_N,
        ST_SQ_D,
        ST_CORDIC,
        ST_ACCUM,
        ST_DIV_START,
        ST_DIVIDE,
        ST_EMIT
    } hbc_state_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_NORM,
        CS_ITER
    } hbc_cordic_state_t;

    typedef enum logic {
        DS_IDLE,
        DS_RUN
    } hbc_div_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hbc_unit_sts_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [Z_W-1:0] hbc_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] val;
        begin
            unique case (idx)
                5'd0:    val = 32'h20000000;
                5'd1:    val = 32'h12E4051E;
                5'd2:    val = 32'h09FB385B;
                5'd3:    val = 32'h051111D4;
                5'd4:    val = 32'h028B0D43;
                5'd5:    val = 32'h0145D7E1;
                5'd6:    val = 32'h00A2F61E;
                5'd7:    val = 32'h00517C55;
                5'd8:    val = 32'h0028BE53;
                5'd9:    val = 32'h00145F2F;
                5'd10:   val = 32'h000A2F98;
                5'd11:   val = 32'h000517CC;
                5'd12:   val = 32'h00028BE6;
                5'd13:   val = 32'h000145F3;
                5'd14:   val = 32'h0000A2FA;
                5'd15:   val = 32'h0000517D;
                5'd16:   val = 32'h000028BE;
                5'd17:   val = 32'h0000145F;
                5'd18:   val = 32'h00000A30;
                5'd19:   val = 32'h00000518;
                5'd20:   val = 32'h0000028C;
                5'd21:   val = 32'h00000146;
                5'd22:   val = 32'h000000A3;
                5'd23:   val = 32'h00000051;
                default: val = '0;
            endcase
            return val;
        end
    endfunction

endpackage

### rtl/hbc_cordic.sv
// Iterative bearing unit: shift normalization, then one CORDIC vectoring step per cycle.
// Depends on hbc_pkg.
module hbc_cordic
    import hbc_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DIFF_W-1:0] de,
    input  logic signed [DIFF_W-1:0] dn,
    output hbc_unit_sts_t            sts,
    output logic [ANG_W-1:0]         bearing
);

    localparam int STEP_W = $clog2(STEPS + 1);

    hbc_cordic_state_t        state_reg, state_next;
    logic signed [VEC_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [DIFF_W-1:0]        me_reg, me_next, mn_reg, mn_next;
    logic [Z_W-1:0]           z_reg, z_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [ANG_W-1:0]         bearing_reg, bearing_next;
    logic                     done_reg, done_next;

    logic signed [VEC_W-1:0]  shx, shy, x_step, y_step;
    logic [Z_W-1:0]           z_step, z_round, atan_val;
    logic [DIFF_W-1:0]        de_mag, dn_mag;

    assign de_mag   = de[DIFF_W-1] ? DIFF_W'(-de) : DIFF_W'(de);
    assign dn_mag   = dn[DIFF_W-1] ? DIFF_W'(-dn) : DIFF_W'(dn);
    assign shx      = x_reg >>> step_reg;
    assign shy      = y_reg >>> step_reg;
    assign atan_val = hbc_atan(ATAN_IDX_W'(step_reg));
    assign z_round  = z_step + 32'h0000_8000;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        me_reg      <= me_next;
        mn_reg      <= mn_next;
        z_reg       <= z_next;
        step_reg    <= step_next;
        bearing_reg <= bearing_next;
    end

    always_comb
    begin
        if (y_reg >= 0)
        begin
            x_step = x_reg + shy;
            y_step = y_reg - shx;
            z_step = z_reg + atan_val;
        end
        else
        begin
            x_step = x_reg - shy;
            y_step = y_reg + shx;
            z_step = z_reg - atan_val;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        me_next      = me_reg;
        mn_next      = mn_reg;
        z_next       = z_reg;
        step_next    = step_reg;
        bearing_next = bearing_reg;
        done_next    = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (start)
                begin
                    x_next  = VEC_W'(dn);
                    y_next  = VEC_W'(de);
                    me_next = de_mag;
                    mn_next = dn_mag;
                    if (de_mag == '0 && dn_mag == '0)
                    begin
                        bearing_next = '0;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        state_next = CS_NORM;
                    end
                end
            end
            CS_NORM:
            begin
                // stop once the larger magnitude reaches 2^32
                if (me_reg[DIFF_W-1] || mn_reg[DIFF_W-1])
                begin
                    step_next  = '0;
                    state_next = CS_ITER;
                    if (x_reg < 0)
                    begin
                        x_next = -x_reg;
                        y_next = -y_reg;
                        z_next = 32'h8000_0000;
                    end
                    else
                    begin
                        z_next = '0;
                    end
                end
                else
                begin
                    x_next  = x_reg <<< 1;
                    y_next  = y_reg <<< 1;
                    me_next = me_reg << 1;
                    mn_next = mn_reg << 1;
                end
            end
            CS_ITER:
            begin
                x_next = x_step;
                y_next = y_step;
                z_next = z_step;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    bearing_next = z_round[Z_W-1 -: ANG_W];
                    done_next    = 1'b1;
                    state_next   = CS_IDLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    assign sts.busy = (state_reg != CS_IDLE);
    assign sts.done = done_reg;
    assign bearing  = bearing_reg;

endmodule

### rtl/hbc_divider.sv
// Restoring divider, one quotient bit per cycle, for the mean error.
// Depends on hbc_pkg.
module hbc_divider
    import hbc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [CNT_W-1:0]    divisor,
    output hbc_unit_sts_t       sts,
    output logic [SUM_W-1:0]    quotient
);

    localparam int ITER_W = $clog2(SUM_W + 1);

    hbc_div_state_t     state_reg, state_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W-1:0]   rem_reg, rem_next, div_reg, div_next;
    logic [ITER_W-1:0]  iter_reg, iter_next;
    logic               done_reg, done_next;
    logic [CNT_W:0]     trial, diff;
    logic               fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        iter_reg <= iter_next;
    end

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        iter_next  = iter_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    quo_next   = dividend;
                    rem_next   = '0;
                    div_next   = divisor;
                    iter_next  = '0;
                    state_next = DS_RUN;
                end
            end
            DS_RUN:
            begin
                // remainder stays below the divisor, so the low bits hold it
                rem_next  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
                quo_next  = {quo_reg[SUM_W-2:0], fits};
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(SUM_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = DS_IDLE;
                end
            end
            default:
            begin
                state_next = DS_IDLE;
            end
        endcase
    end

    assign sts.busy = (state_reg != DS_IDLE);
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/heading_bias_calibrator.sv
// Top level of the heading bias calibrator: sequencer, distance test, bias sum.
// Depends on hbc_pkg, hbc_cordic and hbc_divider.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  in       | in_valid/in_ready, pos_east, pos_north,   | in
//           | reported_heading                          |
//  out      | out_valid/out_ready, mean_error,          | out
//           | latest_error, used_count                  |
//  cfg      | cfg_valid/cfg_ready, travel_limit         | in
//
// A fix that is too close or only sets the anchor passes the difference, the two
// squares and the distance test. A used fix then runs the normalizing shift, one
// bit per cycle, the CORDIC vectoring steps and the restoring divider.
// in_ready is low while a fix is in progress. A result waits in the output
// register; the next fix is accepted meanwhile and holds only at its own end.
// cfg_ready is always high. Reset is asynchronous and active low.
module heading_bias_calibrator
    import hbc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [POS_W-1:0] pos_east,
    input  logic signed [POS_W-1:0] pos_north,
    input  logic [ANG_W-1:0]        reported_heading,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [ANG_W-1:0] mean_error,
    output logic signed [ANG_W-1:0] latest_error,
    output logic [CNT_W-1:0]        used_count,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [SD_W-1:0]         travel_limit
);

    hbc_state_t               state_reg, state_next;
    logic [SD_W-1:0]          sd_reg;
    logic signed [POS_W-1:0]  pe_reg, pn_reg, anchor_e_reg, anchor_e_next;
    logic signed [POS_W-1:0]  anchor_n_reg, anchor_n_next;
    logic                     anchor_set_reg, anchor_set_next;
    logic [ANG_W-1:0]         head_reg;
    logic signed [DIFF_W-1:0] de_reg, dn_reg, de_next, dn_next;
    logic [SQ_W-1:0]          me_reg, mn_reg;
    logic                     big_reg;
    logic [2*SQ_W:0]          acc_reg, acc_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ANG_W-1:0]         err_reg, err_next;
    logic                     neg_reg, neg_next;
    logic [SUM_W-1:0]         dividend;
    logic                     out_valid_reg, out_valid_next;
    logic [ANG_W-1:0]         mean_reg, mean_next, latest_reg, latest_next;
    logic [CNT_W-1:0]         used_reg, used_next;

    logic [DIFF_W-1:0]        de_mag, dn_mag;
    logic [SQ_W-1:0]          mul_a;
    logic [2*SQ_W-1:0]        mul_p;
    logic [SUM_W-1:0]         sum_mag;
    logic                     cordic_start, div_start;
    hbc_unit_sts_t            cordic_sts, div_sts;
    logic [ANG_W-1:0]         bearing;
    logic [SUM_W-1:0]         quotient;
    logic                     out_free;

    hbc_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .de      (de_reg),
        .dn      (dn_reg),
        .sts     (cordic_sts),
        .bearing (bearing)
    );

    hbc_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .sts      (div_sts),
        .quotient (quotient)
    );

    assign de_next = DIFF_W'(pe_reg) - DIFF_W'(anchor_e_reg);
    assign dn_next = DIFF_W'(pn_reg) - DIFF_W'(anchor_n_reg);
    assign de_mag  = de_next[DIFF_W-1] ? DIFF_W'(-de_next) : DIFF_W'(de_next);
    assign dn_mag  = dn_next[DIFF_W-1] ? DIFF_W'(-dn_next) : DIFF_W'(dn_next);
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign dividend = sum_mag + SUM_W'(count_reg >> 1);
    assign mul_p   = mul_a * mul_a;
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (state_reg)
            ST_SQ_E: mul_a = me_reg;
            ST_SQ_N: mul_a = mn_reg;
            default: mul_a = SQ_W'(sd_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sd_reg         <= SD_W'(102);
            anchor_e_reg   <= '0;
            anchor_n_reg   <= '0;
            anchor_set_reg <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            anchor_e_reg   <= anchor_e_next;
            anchor_n_reg   <= anchor_n_next;
            anchor_set_reg <= anchor_set_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                sd_reg <= travel_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pe_reg   <= pos_east;
            pn_reg   <= pos_north;
            head_reg <= reported_heading;
        end
        if (state_reg == ST_DIFF)
        begin
            de_reg  <= de_next;
            dn_reg  <= dn_next;
            me_reg  <= de_mag[SQ_W-1:0];
            mn_reg  <= dn_mag[SQ_W-1:0];
            big_reg <= (de_mag[DIFF_W-1:SQ_W-1] != '0) || (dn_mag[DIFF_W-1:SQ_W-1] != '0);
        end
        acc_reg    <= acc_next;
        err_reg    <= err_next;
        neg_reg    <= neg_next;
        mean_reg   <= mean_next;
        latest_reg <= latest_next;
        used_reg   <= used_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        anchor_e_next   = anchor_e_reg;
        anchor_n_next   = anchor_n_reg;
        anchor_set_next = anchor_set_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        neg_next        = neg_reg;
        mean_next       = mean_reg;
        latest_next     = latest_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cordic_start    = 1'b0;
        div_start       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_SQ_E;
            end
            ST_SQ_E:
            begin
                acc_next   = (2*SQ_W+1)'(mul_p);
                state_next = ST_SQ_N;
            end
            ST_SQ_N:
            begin
                acc_next   = acc_reg + (2*SQ_W+1)'(mul_p);
                state_next = ST_SQ_D;
            end
            ST_SQ_D:
            begin
                priority if (!big_reg && ((2*SQ_W+1)'(mul_p) > acc_reg))
                begin
                    state_next = ST_IDLE;
                end
                else if (!anchor_set_reg)
                begin
                    anchor_set_next = 1'b1;
                    anchor_e_next   = pe_reg;
                    anchor_n_next   = pn_reg;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cordic_start = 1'b1;
                    state_next   = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                if (cordic_sts.done)
                begin
                    err_next   = bearing - head_reg;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM:
            begin
                // freeze the sum once the count saturates
                if (count_reg != '1)
                begin
                    sum_next   = sum_reg + SUM_W'(signed'(err_reg));
                    count_next = count_reg + 1'b1;
                end
                anchor_e_next = pe_reg;
                anchor_n_next = pn_reg;
                state_next    = ST_DIV_START;
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                neg_next   = sum_reg[SUM_W-1];
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free && !div_sts.busy)
                begin
                    mean_next      = neg_reg ? ANG_W'(-quotient[ANG_W-1:0])
                                             : quotient[ANG_W-1:0];
                    latest_next    = err_reg;
                    used_next      = count_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign mean_error   = mean_reg;
    assign latest_error = latest_reg;
    assign used_count   = used_reg;

endmodule

### rtl/hbc_checker.sv
// Port-level checker for the heading bias calibrator, bound to the top level.
// Depends on hbc_pkg and heading_bias_calibrator_assert.svh.
`include "heading_bias_calibrator_assert.svh"

module hbc_checker
    import hbc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [ANG_W-1:0] mean_error,
    input logic [CNT_W-1:0]        used_count
);

    `HBC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
    `HBC_ASSERT_NOW(a_count_nonzero, out_valid, used_count != '0, "result with zero count")
    `HBC_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready), "result while idle")
    `HBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mean_error), "dropped result")

endmodule

bind heading_bias_calibrator hbc_checker u_hbc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .mean_error (mean_error),
    .used_count (used_count)
);

### tb/heading_bias_calibrator_tb.sv
// Self-checking testbench for heading_bias_calibrator: directed and random fixes
// under varying handshake pressure, checked against a built-in bias predictor.
// Depends on hbc_pkg and the heading_bias_calibrator RTL.
`timescale 1ns / 100ps

typedef struct {
    logic signed [15:0] mean_err;
    logic signed [15:0] last_err;
    logic [31:0]        count;
} bias_result_t;

class bias_scoreboard;
    localparam int STEPS = 16;
    bit [31:0]    atan_lut [24];
    bit [15:0]    min_travel;
    longint       anchor_e, anchor_n;
    bit           anchored;
    longint       err_sum;
    bit [31:0]    fixes;
    bias_result_t expected_q[$];
    int           errors;

    function new();
        atan_lut = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                     32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                     32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                     32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                     32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                     32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
        min_travel = 16'd102;
        anchor_e = 0;
        anchor_n = 0;
        anchored = 0;
        err_sum = 0;
        fixes = 0;
        errors = 0;
    endfunction

    function longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // CORDIC vectoring on the normalized difference; z in 2^-32 turn
    function bit [15:0] travel_bearing(longint de, longint dn);
        longint m, x, y, nx;
        int s;
        bit [31:0] z;
        bit [31:0] zr;
        m = (absval(de) > absval(dn)) ? absval(de) : absval(dn);
        if (m == 0)
            return 16'd0;
        s = 0;
        while ((m <<< s) < 64'sh1_0000_0000)
            s++;
        x = dn <<< s;
        y = de <<< s;
        z = 0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            if (y >= 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_lut[i];
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_lut[i];
            end
            x = nx;
        end
        zr = z + 32'h8000;
        return zr[31:16];
    endfunction

    function void set_travel(bit [15:0] v);
        min_travel = v;
    endfunction

    function void note_fix(logic signed [31:0] pe, logic signed [31:0] pn, logic [15:0] hdg);
        longint e, n, de, dn, am, sq;
        bit far;
        bit [15:0] diff;
        bias_result_t r;
        e = pe;
        n = pn;
        de = e - anchor_e;
        dn = n - anchor_n;
        if (absval(de) >= 65536 || absval(dn) >= 65536)
            far = 1;
        else
        begin
            sq = longint'(min_travel) * longint'(min_travel);
            far = (sq <= de * de + dn * dn);
        end
        if (!far)
            return;
        if (!anchored)
        begin
            anchored = 1;
            anchor_e = e;
            anchor_n = n;
            return;
        end
        diff = travel_bearing(de, dn) - hdg;
        r.last_err = $signed(diff);
        if (fixes != 32'hFFFF_FFFF)
        begin
            err_sum += longint'(r.last_err);
            fixes++;
        end
        anchor_e = e;
        anchor_n = n;
        // round half away from zero
        am = (absval(err_sum) + longint'(fixes / 2)) / longint'(fixes);
        am = (err_sum < 0) ? -am : am;
        r.mean_err = am[15:0];
        r.count = fixes;
        expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] m, logic signed [15:0] l, logic [31:0] c);
        bias_result_t r;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result mean=%0d latest=%0d count=%0d", $time, m, l, c);
            errors++;
            return;
        end
        r = expected_q.pop_front();
        if (m !== r.mean_err)
        begin
            $display("%0t: mean_error expected %0d actual %0d", $time, r.mean_err, m);
            errors++;
        end
        if (l !== r.last_err)
        begin
            $display("%0t: latest_error expected %0d actual %0d", $time, r.last_err, l);
            errors++;
        end
        if (c !== r.count)
        begin
            $display("%0t: used_count expected %0d actual %0d", $time, r.count, c);
            errors++;
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module heading_bias_calibrator_tb;
    import hbc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 150;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [POS_W-1:0] pos_east;
    logic signed [POS_W-1:0] pos_north;
    logic [ANG_W-1:0]        reported_heading;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [ANG_W-1:0] mean_error;
    logic signed [ANG_W-1:0] latest_error;
    logic [CNT_W-1:0]        used_count;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [SD_W-1:0]         travel_limit;

    bias_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    logic signed [31:0] cur_e, cur_n;

    heading_bias_calibrator u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .pos_east         (pos_east),
        .pos_north        (pos_north),
        .reported_heading (reported_heading),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .mean_error       (mean_error),
        .latest_error     (latest_error),
        .used_count       (used_count),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .travel_limit     (travel_limit)
    );

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        pos_east = 0;
        pos_north = 0;
        reported_heading = 0;
        cfg_valid = 0;
        travel_limit = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sb = new();
    end

    always #2 clk = ~clk;

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // Monitor: feed the predictor and check results at each transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_travel(travel_limit);
            if (in_valid && in_ready)
                sb.note_fix(pos_east, pos_north, reported_heading);
            if (out_valid && out_ready)
                sb.check_result(mean_error, latest_error, used_count);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** heading_bias_calibrator: FAILED **");
            $finish;
        end
    end

    task automatic send_fix(logic signed [31:0] e, logic signed [31:0] n, logic [15:0] h);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_east <= e;
        pos_north <= n;
        reported_heading <= h;
        cur_e = e;
        cur_n = n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold the input channel until every result is back and the block is idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_travel(logic [15:0] v);
        drain();
        cfg_valid <= 1'b1;
        travel_limit <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_fix();
        int k;
        logic signed [31:0] d_e, d_n;
        logic [15:0] h;
        h = 16'($urandom());
        if ($urandom_range(0, 9) == 0)
            h = ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'hFFFF;
        if ($urandom_range(0, 9) == 0)
        begin
            send_fix($urandom(), $urandom(), h);
            return;
        end
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 31) : $urandom_range(0, 20);
        d_e = $signed($urandom()) >>> (31 - k);
        d_n = $signed($urandom()) >>> (31 - k);
        send_fix(cur_e + d_e, cur_n + d_n, h);
    endtask

    initial
    begin
        bit [15:0] travel_set[4];
        travel_set = '{16'd300, 16'hFFFF, 16'd0, 16'd1};
        cur_e = 0;
        cur_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset travel threshold
        send_fix(32'sd10, 32'sd10, 16'h0000);           // too close to origin
        send_fix(32'sd0, 32'sd200, 16'h0000);           // sets anchor
        send_fix(32'sd0, 32'sd400, 16'h8000);           // exact half turn
        send_fix(32'sd200, 32'sd400, 16'h4000);         // due east
        send_fix(32'sd200, 32'sd200, 16'hFFFF);         // southward, north < 0
        send_fix(32'sd150, 32'sd150, 16'h0000);         // under threshold
        send_fix(32'sh7FFFFFFF, 32'sh80000000, 16'h0000);
        send_fix(32'sh80000000, 32'sh7FFFFFFF, 16'hFFFF);
        send_fix(32'sh80000000, 32'sh80000000, 16'h1234);
        send_fix(32'sd0, 32'sd0, 16'hA5A5);
        send_fix(-32'sd1, -32'sd1, 16'h0001);
        write_travel(16'd0);
        send_fix(-32'sd1, -32'sd1, 16'h0000);           // one unit west and south of the anchor
        send_fix(32'sd3, -32'sd7, 16'h7FFF);
        write_travel(16'hFFFF);
        send_fix(32'sd30000, -32'sd7, 16'h0000);        // too short
        send_fix(32'sd60000, 32'sd30000, 16'h0000);
        send_fix(32'sd60000, 32'sd95535, 16'hC000);     // exactly at threshold
        write_travel(16'd1);
        send_fix(32'sd60001, 32'sd95535, 16'h4000);

        // random phases: no idling, sender idle, receiver stall, both
        for (int p = 0; p < 4; p++)
        begin
            write_travel((p == 0) ? 16'($urandom_range(0, 2000)) : travel_set[p]);
            send_idle_pct  = (p == 1) ? 49 : (p == 3) ? 37 : 0;
            recv_stall_pct = (p == 2) ? 49 : (p == 3) ? 37 : 0;
            for (int i = 0; i < 220; i++)
            begin
                if (p == 1 && i == 110)
                    drain();
                random_fix();
            end
        end
        write_travel(16'd102);
        for (int i = 0; i < 20; i++)
            random_fix();

        drain();
        if (sb.errors == 0)
            $display("** heading_bias_calibrator: PASSED **");
        else
            $display("** heading_bias_calibrator: FAILED **");
        $finish;
    end
endmodule
